// ===== rtl/rlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpm_pkg
// Shared types, constants and helpers for the longest prefix match route table.
// ----------------------------------------------------------------------------
package rlpm_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

  // Request codes.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // Status codes.
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [3:0]  iface;
    logic [5:0]  ones;
  } route_entry_t;

  // Adder tree population count of a 32-bit mask.
  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

// ===== rtl/route_longest_prefix_match_core.sv =====
// An add or an unknown request goes from idle straight to the response step, which posts its
// result; a remove or lookup first scans the stored routes, and a remove that hits shifts them down.
// Requests are taken one at a time: the next is accepted once the sequencer is back in idle, and
// a previous result still stalled at the output holds the sequencer in the response step.
// Reset: rst_ni clears the route count and the sequencer; route storage is not cleared.
// ----------------------------------------------------------------------------
// route_longest_prefix_match_core
// IPv4 route table with add, remove and longest prefix match lookup requests,
// scanned sequentially through a single route memory.
// ----------------------------------------------------------------------------
module route_longest_prefix_match_core
  import rlpm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] ip_addr_i,
  input  logic [31:0] net_mask_i,
  input  logic [31:0] hop_addr_i,
  input  logic [3:0]  iface_in_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] hop_out_o,
  output logic [3:0]  iface_out_o,
  output logic [5:0]  prefix_len_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0] rd_idx_q;
  route_entry_t     rd_data_q;

  logic [1:0]  req_q, req_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] mask_q, mask_d;
  logic        hit_q, hit_d;
  logic [31:0] best_hop_q, best_hop_d;
  logic [3:0]  best_iface_q, best_iface_d;
  logic [5:0]  best_ones_q, best_ones_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] hop_q, hop_d;
  logic [3:0]  iface_q, iface_d;
  logic [5:0]  plen_q, plen_d;

  route_entry_t mem_q [ROUTE_ENTRIES];
  logic         mem_we;
  logic [IDX_W-1:0] mem_waddr;
  route_entry_t mem_wdata;
  route_entry_t new_entry;

  logic accept;
  logic issue;
  logic out_free;
  logic [CNT_W-1:0] shift_dst;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign shift_dst = rd_idx_q - CNT_W'(1);

  always_comb begin
    new_entry.net   = ip_addr_i;
    new_entry.mask  = net_mask_i;
    new_entry.hop   = hop_addr_i;
    new_entry.iface = iface_in_i;
    new_entry.ones  = popcount32(net_mask_i);
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    req_d        = req_q;
    addr_d       = addr_q;
    mask_d       = mask_q;
    hit_d        = hit_q;
    best_hop_d   = best_hop_q;
    best_iface_d = best_iface_q;
    best_ones_d  = best_ones_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    hop_d        = hop_q;
    iface_d      = iface_q;
    plen_d       = plen_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[IDX_W-1:0];
    mem_wdata    = new_entry;
    issue        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d       = req_type_i;
          addr_d      = ip_addr_i;
          mask_d      = net_mask_i;
          hit_d       = 1'b0;
          best_ones_d = '0;
          scan_d      = '0;
          case (req_type_i)
            REQ_ADD: begin
              if (count_q != CNT_W'(ROUTE_ENTRIES)) begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
                hit_d   = 1'b1;
              end
              state_d = ST_RESP;
            end
            REQ_REMOVE, REQ_LOOKUP: state_d = ST_SCAN;
            default: state_d = ST_RESP;
          endcase
        end
      end

      ST_SCAN: begin
        issue = scan_q < count_q;
        if (issue) begin
          scan_d = scan_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          if (req_q == REQ_REMOVE) begin
            // Reads already in flight continue straight into the shift phase.
            if (rd_data_q.net == addr_q && rd_data_q.mask == mask_q) begin
              hit_d   = 1'b1;
              state_d = ST_SHIFT;
            end
          end else if ((addr_q & rd_data_q.mask) == rd_data_q.net &&
                       (!hit_q || rd_data_q.ones > best_ones_q)) begin
            hit_d        = 1'b1;
            best_hop_d   = rd_data_q.hop;
            best_iface_d = rd_data_q.iface;
            best_ones_d  = rd_data_q.ones;
          end
        end
        if (!rd_vld_q && !issue) begin
          state_d = ST_RESP;
        end
      end

      ST_SHIFT: begin
        issue = scan_q < count_q;
        if (issue) begin
          scan_d = scan_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = shift_dst[IDX_W-1:0];
          mem_wdata = rd_data_q;
        end
        if (!rd_vld_q && !issue) begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (hit_q) begin
            status_d = STS_OK;
          end else if (req_q == REQ_ADD) begin
            status_d = STS_FULL;
          end else begin
            status_d = STS_NOTFOUND;
          end
          if (hit_q && req_q == REQ_LOOKUP) begin
            hop_d   = best_hop_q;
            iface_d = best_iface_q;
            plen_d  = best_ones_q;
          end else begin
            hop_d   = '0;
            iface_d = '0;
            plen_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    rd_vld_d = issue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    rd_idx_q     <= scan_q;
    req_q        <= req_d;
    addr_q       <= addr_d;
    mask_q       <= mask_d;
    hit_q        <= hit_d;
    best_hop_q   <= best_hop_d;
    best_iface_q <= best_iface_d;
    best_ones_q  <= best_ones_d;
    status_q     <= status_d;
    hop_q        <= hop_d;
    iface_q      <= iface_d;
    plen_q       <= plen_d;
  end

  // Route memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[scan_q[IDX_W-1:0]];
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign hop_out_o    = hop_q;
  assign iface_out_o  = iface_q;
  assign prefix_len_o = plen_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ROUTE_ENTRIES))
    else $error("route count exceeds table size");

  a_shift_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && rd_vld_q) |-> (rd_idx_q != '0))
    else $error("shift writes below entry zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request accepted while sequencer stays idle");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RESP))
    else $error("result posted outside the response step");

endmodule
